// ===== hw/rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Types, constants and codes shared by the cascaded timebase timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int FastTimers  = 16;
  localparam int MidTimers   = 16;
  localparam int SlowTimers  = 16;
  localparam int TotalTimers = FastTimers + MidTimers + SlowTimers;
  localparam int AddrW       = $clog2(TotalTimers);
  localparam int CntW        = $clog2(TotalTimers + 1);
  localparam int ValueW      = 15;
  localparam int SubW        = 4;
  localparam int RuntimeW    = 32;

  localparam logic [ValueW-1:0] TimerCap = {ValueW{1'b1}};
  localparam logic [SubW-1:0]   Prescale = SubW'(10);

  typedef enum logic [1:0] {
    ModeTick  = 2'd0,
    ModeWrite = 2'd1,
    ModeRead  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StResp
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [5:0]        timer_index;
    logic [ValueW-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0]   read_value;
    logic                pulse_1ms;
    logic                pulse_10ms;
    logic                pulse_100ms;
    logic                pulse_1000ms;
    logic                run_led;
    logic [RuntimeW-1:0] runtime_seconds;
  } result_t;

  typedef struct packed {
    logic accept;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic item_tick;
    logic walk_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/ctb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctb_ctrl
// Sequencer: accepts a word, walks the timer store on a tick, strobes result.
// ----------------------------------------------------------------------------
module ctb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ctb_pkg::dp_status_t status_i,
  output ctb_pkg::ctl_cmd_t   cmd_o,
  output logic                busy,
  output logic                done_o
);

  ctb_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctb_pkg::StIdle: begin
        if (start) begin
          state_d = status_i.item_tick ? ctb_pkg::StWalk : ctb_pkg::StResp;
        end
      end
      ctb_pkg::StWalk: begin
        if (status_i.walk_last) begin
          state_d = ctb_pkg::StResp;
        end
      end
      ctb_pkg::StResp: begin
        state_d = ctb_pkg::StIdle;
      end
      default: begin
        state_d = ctb_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ctb_pkg::StIdle: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ctb_pkg::StWalk: begin
        cmd_o.step = 1'b1;
      end
      ctb_pkg::StResp: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ctb_datapath.sv =====
// ----------------------------------------------------------------------------
// ctb_datapath
// Prescaler chain, pulse flags, runtime counter and the timer store.
// ----------------------------------------------------------------------------
module ctb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctb_pkg::item_t      item_i,
  input  ctb_pkg::ctl_cmd_t   cmd_i,
  output ctb_pkg::dp_status_t status_o,
  output ctb_pkg::result_t    result_o
);

  logic [ctb_pkg::ValueW-1:0]   mem [ctb_pkg::TotalTimers];
  logic [ctb_pkg::TotalTimers-1:0] valid_q, valid_d;

  logic [ctb_pkg::SubW-1:0]     ms_q, ms_d, tens_q, tens_d, hund_q, hund_d;
  logic [3:0]                   flags_q, flags_d;
  logic                         led_q, led_d;
  logic [ctb_pkg::RuntimeW-1:0] runtime_q, runtime_d;
  logic [ctb_pkg::AddrW-1:0]    walk_cnt_q, walk_cnt_d;
  logic [ctb_pkg::CntW-1:0]     walk_end_q, walk_end_d;
  logic                         wb_q;
  logic [ctb_pkg::AddrW-1:0]    wb_addr_q;
  logic                         rsel_q, rsel_d;
  logic [ctb_pkg::ValueW-1:0]   rd_data_q;
  logic                         rd_valid_q;

  logic                         index_ok, is_tick, is_write, is_read;
  logic                         ev10, ev100, ev1000;
  logic [ctb_pkg::SubW-1:0]     tens_inc, hund_inc;
  logic [ctb_pkg::ValueW-1:0]   rd_value, bumped;
  logic                         wr_en, rd_en;
  logic [ctb_pkg::AddrW-1:0]    wr_addr, rd_addr;
  logic [ctb_pkg::ValueW-1:0]   wr_data;

  assign index_ok = 32'(item_i.timer_index) < ctb_pkg::TotalTimers;
  assign is_tick  = item_i.mode == ctb_pkg::ModeTick;
  assign is_write = item_i.mode == ctb_pkg::ModeWrite;
  assign is_read  = item_i.mode == ctb_pkg::ModeRead;

  assign ev10     = ms_q >= ctb_pkg::Prescale;
  assign tens_inc = ev10 ? tens_q + ctb_pkg::SubW'(1) : tens_q;
  assign ev100    = tens_inc >= ctb_pkg::Prescale;
  assign hund_inc = ev100 ? hund_q + ctb_pkg::SubW'(1) : hund_q;
  assign ev1000   = hund_inc >= ctb_pkg::Prescale;

  assign rd_value = rd_valid_q ? rd_data_q : '0;
  assign bumped   = (rd_value < ctb_pkg::TimerCap) ? rd_value + ctb_pkg::ValueW'(1) : rd_value;

  assign wr_en   = (cmd_i.accept && is_write && index_ok) || wb_q;
  assign wr_addr = wb_q ? wb_addr_q : ctb_pkg::AddrW'(item_i.timer_index);
  assign wr_data = wb_q ? bumped : item_i.write_value;
  assign rd_en   = (cmd_i.accept && is_read && index_ok) || cmd_i.step;
  assign rd_addr = cmd_i.step ? walk_cnt_q : ctb_pkg::AddrW'(item_i.timer_index);

  always_comb begin
    ms_d       = ms_q;
    tens_d     = tens_q;
    hund_d     = hund_q;
    flags_d    = flags_q;
    led_d      = led_q;
    runtime_d  = runtime_q;
    walk_cnt_d = walk_cnt_q;
    walk_end_d = walk_end_q;
    rsel_d     = rsel_q;
    valid_d    = valid_q;
    if (wr_en) begin
      valid_d[wr_addr] = 1'b1;
    end
    if (cmd_i.accept) begin
      rsel_d = is_read && index_ok;
      if (is_tick) begin
        ms_d       = (ev10 ? '0 : ms_q) + ctb_pkg::SubW'(1);
        tens_d     = ev100 ? '0 : tens_inc;
        hund_d     = ev1000 ? '0 : hund_inc;
        flags_d    = flags_q ^ {ev1000, ev100, ev10, 1'b1};
        led_d      = ev100 ? flags_d[2] : led_q;
        runtime_d  = ev1000 ? runtime_q + ctb_pkg::RuntimeW'(1) : runtime_q;
        walk_cnt_d = '0;
        if (ev100) begin
          walk_end_d = ctb_pkg::CntW'(ctb_pkg::TotalTimers);
        end else if (ev10) begin
          walk_end_d = ctb_pkg::CntW'(ctb_pkg::FastTimers + ctb_pkg::MidTimers);
        end else begin
          walk_end_d = ctb_pkg::CntW'(ctb_pkg::FastTimers);
        end
      end
    end else if (cmd_i.step) begin
      walk_cnt_d = walk_cnt_q + ctb_pkg::AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q       <= '0;
      tens_q     <= '0;
      hund_q     <= '0;
      flags_q    <= '0;
      led_q      <= 1'b0;
      runtime_q  <= '0;
      valid_q    <= '0;
      walk_cnt_q <= '0;
      walk_end_q <= '0;
      wb_q       <= 1'b0;
      rsel_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      ms_q       <= ms_d;
      tens_q     <= tens_d;
      hund_q     <= hund_d;
      flags_q    <= flags_d;
      led_q      <= led_d;
      runtime_q  <= runtime_d;
      valid_q    <= valid_d;
      walk_cnt_q <= walk_cnt_d;
      walk_end_q <= walk_end_d;
      wb_q       <= cmd_i.step;
      rsel_q     <= rsel_d;
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= walk_cnt_q;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign status_o.item_tick = is_tick;
  assign status_o.walk_last =
    (ctb_pkg::CntW'(walk_cnt_q) + ctb_pkg::CntW'(1)) == walk_end_q;

  assign result_o.read_value      = rsel_q ? rd_value : '0;
  assign result_o.pulse_1ms       = flags_q[0];
  assign result_o.pulse_10ms      = flags_q[1];
  assign result_o.pulse_100ms     = flags_q[2];
  assign result_o.pulse_1000ms    = flags_q[3];
  assign result_o.run_led         = led_q;
  assign result_o.runtime_seconds = runtime_q;

endmodule

// ===== hw/rtl/cascaded_timebase_timer_bank.sv =====
// ----------------------------------------------------------------------------
// cascaded_timebase_timer_bank
// Millisecond timebase with 10/100/1000 ms cascades and three timer banks.
// ----------------------------------------------------------------------------
// A word is taken on item_i at a rising edge where start is high and busy is
// low. Mode tick advances the timebase, mode write stores a timer, mode read
// fetches one; any other mode only reports the current status.
// Each accepted word gives exactly one result word on result_o, shown for a
// single cycle while done_o is high. The receiver cannot stall it.
// Write, read and unused modes go from accept straight to the result state.
// A tick walks the timer store one timer per cycle through its single
// read and write port, read-modify-write pipelined: the 1 ms bank, also
// the 10 ms bank when it is due, and also the 100 ms bank when that is due.
// busy is high from the cycle after accept until the result cycle ends.
// Reset clears the timebase, flags, runtime and all timers at once; the
// block accepts a word in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module cascaded_timebase_timer_bank (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ctb_pkg::item_t   item_i,
  output logic             done_o,
  output ctb_pkg::result_t result_o
);

  ctb_pkg::ctl_cmd_t   cmd;
  ctb_pkg::dp_status_t status;

  ctb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  ctb_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ===== hw/rtl/ctb_checker.sv =====
// ----------------------------------------------------------------------------
// ctb_assert
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
module ctb_assert (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input ctb_pkg::item_t   item_i,
  input logic             done_o
);

  a_done_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe seen while not busy");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe not followed by idle");

  a_short_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode != ctb_pkg::ModeTick) |=> done_o)
    else $error("non-tick word did not complete in one cycle");

endmodule

bind cascaded_timebase_timer_bank ctb_assert u_ctb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .item_i (item_i),
  .done_o (done_o)
);

// ===== tb/ctb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctb_checker
// Watches the command and result channels of the timer bank and checks them.
// ----------------------------------------------------------------------------
// Every accepted command word is run through a cycle-free model of the
// timebase and timer store. The predicted result word is queued, and each
// strobed result word is compared field by field with the oldest one queued.
// The number of failures, the number of words still awaited and the number
// of words compared are handed to the testbench top.
// ----------------------------------------------------------------------------
module ctb_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  ctb_pkg::item_t   item_i,
  input  logic             done_o,
  input  ctb_pkg::result_t result_o,
  output int               error_count_o,
  output int               awaited_o,
  output int               compared_o
);

  logic [ctb_pkg::SubW-1:0]     ms_sub;
  logic [ctb_pkg::SubW-1:0]     tens_sub;
  logic [ctb_pkg::SubW-1:0]     hund_sub;
  logic [3:0]                   flags;
  logic                         led;
  logic [ctb_pkg::ValueW-1:0]   timers [ctb_pkg::TotalTimers];
  logic [ctb_pkg::RuntimeW-1:0] seconds;

  ctb_pkg::result_t predicted_q [$];
  int               err_cnt;
  int               cmp_cnt;

  function automatic void bump_bank(input int first, input int count);
    for (int k = first; k < first + count && k < ctb_pkg::TotalTimers; k++) begin
      if (timers[k] != ctb_pkg::TimerCap) begin
        timers[k] = timers[k] + 1'b1;
      end
    end
  endfunction

  function automatic ctb_pkg::result_t predict_result(input ctb_pkg::item_t w);
    ctb_pkg::result_t r;
    r = '0;
    case (w.mode)
      ctb_pkg::ModeTick: begin
        flags[0] = ~flags[0];
        bump_bank(0, ctb_pkg::FastTimers);
        if (ms_sub >= ctb_pkg::Prescale) begin
          flags[1] = ~flags[1];
          bump_bank(ctb_pkg::FastTimers, ctb_pkg::MidTimers);
          tens_sub = tens_sub + 1'b1;
          ms_sub   = '0;
        end
        if (tens_sub >= ctb_pkg::Prescale) begin
          flags[2] = ~flags[2];
          bump_bank(ctb_pkg::FastTimers + ctb_pkg::MidTimers, ctb_pkg::SlowTimers);
          hund_sub = hund_sub + 1'b1;
          tens_sub = '0;
          led      = flags[2];
        end
        if (hund_sub >= ctb_pkg::Prescale) begin
          flags[3] = ~flags[3];
          seconds  = seconds + 1'b1;
          hund_sub = '0;
        end
        ms_sub = ms_sub + 1'b1;
      end
      ctb_pkg::ModeWrite: begin
        if (w.timer_index < ctb_pkg::TotalTimers) begin
          timers[w.timer_index] = w.write_value;
        end
      end
      ctb_pkg::ModeRead: begin
        if (w.timer_index < ctb_pkg::TotalTimers) begin
          r.read_value = timers[w.timer_index];
        end
      end
      default: ;
    endcase
    r.pulse_1ms       = flags[0];
    r.pulse_10ms      = flags[1];
    r.pulse_100ms     = flags[2];
    r.pulse_1000ms    = flags[3];
    r.run_led         = led;
    r.runtime_seconds = seconds;
    return r;
  endfunction

  function automatic void compare_field(input string label,
                                        input logic [ctb_pkg::RuntimeW-1:0] want,
                                        input logic [ctb_pkg::RuntimeW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ctb_pkg::result_t want;
    if (!rst_ni) begin
      ms_sub   = '0;
      tens_sub = '0;
      hund_sub = '0;
      flags    = '0;
      led      = 1'b0;
      seconds  = '0;
      for (int k = 0; k < ctb_pkg::TotalTimers; k++) begin
        timers[k] = '0;
      end
      predicted_q.delete();
      err_cnt = 0;
      cmp_cnt = 0;
      error_count_o <= 0;
      awaited_o     <= 0;
      compared_o    <= 0;
    end else begin
      if (done_o === 1'b1) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: result word with nothing awaited, expected none, got %h",
                   $time, result_o);
          err_cnt++;
        end else begin
          want = predicted_q.pop_front();
          cmp_cnt++;
          compare_field("read_value", ctb_pkg::RuntimeW'(want.read_value),
                        ctb_pkg::RuntimeW'(result_o.read_value));
          compare_field("pulse_1ms", ctb_pkg::RuntimeW'(want.pulse_1ms),
                        ctb_pkg::RuntimeW'(result_o.pulse_1ms));
          compare_field("pulse_10ms", ctb_pkg::RuntimeW'(want.pulse_10ms),
                        ctb_pkg::RuntimeW'(result_o.pulse_10ms));
          compare_field("pulse_100ms", ctb_pkg::RuntimeW'(want.pulse_100ms),
                        ctb_pkg::RuntimeW'(result_o.pulse_100ms));
          compare_field("pulse_1000ms", ctb_pkg::RuntimeW'(want.pulse_1000ms),
                        ctb_pkg::RuntimeW'(result_o.pulse_1000ms));
          compare_field("run_led", ctb_pkg::RuntimeW'(want.run_led),
                        ctb_pkg::RuntimeW'(result_o.run_led));
          compare_field("runtime_seconds", want.runtime_seconds,
                        result_o.runtime_seconds);
        end
      end
      if (start && !busy) begin
        predicted_q.push_back(predict_result(item_i));
      end
      error_count_o <= err_cnt;
      awaited_o     <= predicted_q.size();
      compared_o    <= cmp_cnt;
    end
  end

endmodule

// ===== tb/tb_cascaded_timebase_timer_bank.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_timebase_timer_bank
// Stimulus and verdict for the cascaded timebase timer bank.
// ----------------------------------------------------------------------------
// A short directed sequence covers reset values, saturation, writes and reads
// past the banks and the unused mode. Random command words follow, mostly
// ticks so that the 10, 100 and 1000 ms cascades are reached, under three
// sender idle settings. The checker module predicts and compares; a watchdog
// ends the run if the channels fall silent.
// ----------------------------------------------------------------------------
module tb_cascaded_timebase_timer_bank;

  localparam logic [1:0] ModeSpare     = 2'd3;
  localparam int         WatchdogLimit = 2000;
  localparam int         PhaseWords    = 550;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  ctb_pkg::item_t   item;
  logic             done_o;
  ctb_pkg::result_t result_o;

  int error_count;
  int awaited;
  int compared;
  int quiet_cycles;
  int n_tick;
  int n_write;
  int n_read;
  int n_spare;

  cascaded_timebase_timer_bank DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item),
    .done_o   (done_o),
    .result_o (result_o)
  );

  ctb_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .done_o        (done_o),
    .result_o      (result_o),
    .error_count_o (error_count),
    .awaited_o     (awaited),
    .compared_o    (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic ctb_pkg::item_t make_word(input logic [1:0] mode,
                                               input logic [5:0] idx,
                                               input logic [ctb_pkg::ValueW-1:0] value);
    ctb_pkg::item_t w;
    w.mode        = mode;
    w.timer_index = idx;
    w.write_value = value;
    return w;
  endfunction

  function automatic ctb_pkg::item_t random_word();
    ctb_pkg::item_t w;
    int             pick;
    pick = $urandom_range(99);
    if (pick < 72) begin
      w.mode = ctb_pkg::ModeTick;
    end else if (pick < 84) begin
      w.mode = ctb_pkg::ModeWrite;
    end else if (pick < 98) begin
      w.mode = ctb_pkg::ModeRead;
    end else begin
      w.mode = ModeSpare;
    end
    if ($urandom_range(99) < 8) begin
      w.timer_index = 6'($urandom_range(63, ctb_pkg::TotalTimers));
    end else begin
      w.timer_index = 6'($urandom_range(ctb_pkg::TotalTimers - 1));
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      w.write_value = '0;
    end else if (pick == 1) begin
      w.write_value = ctb_pkg::ValueW'(ctb_pkg::TimerCap - $urandom_range(3));
    end else begin
      w.write_value = ctb_pkg::ValueW'($urandom_range(32767));
    end
    return w;
  endfunction

  task automatic send_word(input ctb_pkg::item_t w);
    start <= 1'b1;
    item  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (w.mode)
      ctb_pkg::ModeTick:  n_tick++;
      ctb_pkg::ModeWrite: n_write++;
      ctb_pkg::ModeRead:  n_read++;
      default:            n_spare++;
    endcase
  endtask

  task automatic hold_off(input int pct);
    int n;
    n = 0;
    while (n < 30 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int pct;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item         = '0;
    quiet_cycles = 0;
    n_tick       = 0;
    n_write      = 0;
    n_read       = 0;
    n_spare      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(make_word(ctb_pkg::ModeRead, 6'd0, '0));
    send_word(make_word(ctb_pkg::ModeRead, 6'(ctb_pkg::TotalTimers - 1), '0));
    send_word(make_word(ctb_pkg::ModeWrite, 6'd0, ctb_pkg::TimerCap - 1'b1));
    send_word(make_word(ctb_pkg::ModeWrite, 6'd1, ctb_pkg::TimerCap));
    send_word(make_word(ctb_pkg::ModeWrite, 6'(ctb_pkg::FastTimers), 15'd5));
    send_word(make_word(ctb_pkg::ModeWrite, 6'(ctb_pkg::TotalTimers - 1), 15'h5555));
    send_word(make_word(ctb_pkg::ModeWrite,
                        6'(ctb_pkg::FastTimers + ctb_pkg::MidTimers), 15'h2AAA));
    send_word(make_word(ctb_pkg::ModeWrite, 6'd63, ctb_pkg::TimerCap));
    send_word(make_word(ctb_pkg::ModeRead, 6'd63, ctb_pkg::TimerCap));
    send_word(make_word(ctb_pkg::ModeRead, 6'(ctb_pkg::TotalTimers), '0));
    send_word(make_word(ModeSpare, 6'd33, ctb_pkg::TimerCap));
    send_word(make_word(ctb_pkg::ModeTick, 6'd0, '0));
    send_word(make_word(ctb_pkg::ModeTick, 6'd63, ctb_pkg::TimerCap));
    send_word(make_word(ctb_pkg::ModeRead, 6'd0, '0));
    send_word(make_word(ctb_pkg::ModeRead, 6'd1, '0));
    send_word(make_word(ctb_pkg::ModeRead, 6'(ctb_pkg::FastTimers), '0));
    send_word(make_word(ctb_pkg::ModeRead, 6'(ctb_pkg::TotalTimers - 1), '0));
    send_word(make_word(ctb_pkg::ModeRead,
                        6'(ctb_pkg::FastTimers + ctb_pkg::MidTimers), '0));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 37 : (phase == 1) ? 87 : 0;
      for (int i = 0; i < PhaseWords; i++) begin
        hold_off(pct);
        if ($urandom_range(199) == 0) begin
          drain();
        end
        send_word(random_word());
      end
      drain();
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d words: %0d ticks, %0d timer writes, %0d timer reads, %0d unused.",
             n_tick + n_write + n_read + n_spare, n_tick, n_write, n_read, n_spare);
    $display("Compared %0d result words across three sender idle settings.", compared);
    if (error_count == 0 && awaited == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_ctrl.sv
hw/rtl/ctb_datapath.sv
hw/rtl/cascaded_timebase_timer_bank.sv
hw/rtl/ctb_checker.sv
tb/ctb_checker.sv
tb/tb_cascaded_timebase_timer_bank.sv
